// File: rtl/core/battery_protection_supervisor_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the battery protection supervisor
// Shared property wrappers, clocked on the rising edge, idle during reset.
// ---------------------------------------------------------------------------
`ifndef BATTERY_PROTECTION_SUPERVISOR_ASSERT_SVH
`define BATTERY_PROTECTION_SUPERVISOR_ASSERT_SVH

// same-cycle implication
`define BPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bps assertion failed");

// next-cycle implication
`define BPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bps assertion failed");

`endif

// File: rtl/core/bps_pkg.sv
// ---------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the battery protection supervisor.
// ---------------------------------------------------------------------------
package bps_pkg;

	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned CNT_W      = 4;

	localparam logic [CNT_W-1:0] CNT_MAX             = 4'd15;
	localparam logic [CNT_W-1:0] VOLT_TRIP_COUNT     = 4'd10;
	localparam logic [CNT_W-1:0] CURRENT_TRIP_COUNT  = 4'd5;
	localparam logic [CNT_W-1:0] TEMP_TRIP_COUNT     = 4'd4;
	localparam logic [CNT_W-1:0] BAND_DEBOUNCE_COUNT = 4'd10;

	typedef enum logic [2:0] {
		REG_CRIT_MIN_MV     = 3'd0,
		REG_CRIT_MAX_MV     = 3'd1,
		REG_REC_MIN_MV      = 3'd2,
		REG_REC_MAX_MV      = 3'd3,
		REG_CAUTION_MAX_MV  = 3'd4,
		REG_CHARGE_LIMIT    = 3'd5,
		REG_DISCHARGE_LIMIT = 3'd6,
		REG_TEMP_LIMIT      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        [15:0] crit_min_mv;
		logic        [15:0] crit_max_mv;
		logic        [15:0] rec_min_mv;
		logic        [15:0] rec_max_mv;
		logic        [15:0] caution_max_mv;
		logic signed [15:0] charge_limit;
		logic signed [15:0] discharge_limit;
		logic signed [11:0] temp_limit;
	} cfg_t;

	typedef struct packed {
		logic        [15:0] min_cell_mv;
		logic        [15:0] max_cell_mv;
		logic signed [15:0] pack_current;
		logic signed [11:0] hottest_temp;
	} item_t;

	typedef struct packed {
		logic pack_enable;
		logic array_enable;
		logic undervolt_latched;
		logic overvolt_latched;
		logic system_ready;
		logic fault_trip;
		logic shutdown_halted;
	} result_t;

endpackage

// File: rtl/core/bps_if.sv
// ---------------------------------------------------------------------------
// bps_if
// Valid/ready channels carrying measurement words in and result words out.
// ---------------------------------------------------------------------------
interface bps_item_if;
	import bps_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bps_result_if;
	import bps_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/bps_cfg_regs.sv
// ---------------------------------------------------------------------------
// bps_cfg_regs
// APB-style register file holding the supervisor limits.
// ---------------------------------------------------------------------------
module bps_cfg_regs
	import bps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crit_min_mv     <= 16'd2500;
			cfg_q.crit_max_mv     <= 16'd4300;
			cfg_q.rec_min_mv      <= 16'd2800;
			cfg_q.rec_max_mv      <= 16'd4200;
			cfg_q.caution_max_mv  <= 16'd4100;
			cfg_q.charge_limit    <= -16'sd5000;
			cfg_q.discharge_limit <= 16'sd10000;
			cfg_q.temp_limit      <= 12'sd600;
		end else if (wr_en) begin
			unique case (idx)
				REG_CRIT_MIN_MV:     cfg_q.crit_min_mv     <= pwdata[15:0];
				REG_CRIT_MAX_MV:     cfg_q.crit_max_mv     <= pwdata[15:0];
				REG_REC_MIN_MV:      cfg_q.rec_min_mv      <= pwdata[15:0];
				REG_REC_MAX_MV:      cfg_q.rec_max_mv      <= pwdata[15:0];
				REG_CAUTION_MAX_MV:  cfg_q.caution_max_mv  <= pwdata[15:0];
				REG_CHARGE_LIMIT:    cfg_q.charge_limit    <= pwdata[15:0];
				REG_DISCHARGE_LIMIT: cfg_q.discharge_limit <= pwdata[15:0];
				REG_TEMP_LIMIT:      cfg_q.temp_limit      <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_CRIT_MIN_MV:     prdata[15:0] = cfg_q.crit_min_mv;
			REG_CRIT_MAX_MV:     prdata[15:0] = cfg_q.crit_max_mv;
			REG_REC_MIN_MV:      prdata[15:0] = cfg_q.rec_min_mv;
			REG_REC_MAX_MV:      prdata[15:0] = cfg_q.rec_max_mv;
			REG_CAUTION_MAX_MV:  prdata[15:0] = cfg_q.caution_max_mv;
			REG_CHARGE_LIMIT:    prdata[15:0] = cfg_q.charge_limit;
			REG_DISCHARGE_LIMIT: prdata[15:0] = cfg_q.discharge_limit;
			REG_TEMP_LIMIT:      prdata[11:0] = cfg_q.temp_limit;
			default: ;
		endcase
	end

endmodule

// File: rtl/core/bps_core.sv
// ---------------------------------------------------------------------------
// bps_core
// Input register, fault/band state update and result register.
// ---------------------------------------------------------------------------
module bps_core
	import bps_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	bps_item_if.sink     item,
	bps_result_if.source result
);

	typedef struct packed {
		logic [CNT_W-1:0] volt_cnt;
		logic [CNT_W-1:0] cur_cnt;
		logic [CNT_W-1:0] temp_cnt;
		logic [CNT_W-1:0] uv_cnt;
		logic [CNT_W-1:0] ov_cnt;
		logic [CNT_W-1:0] ov_clr_cnt;
		logic             uv_latch;
		logic             ov_latch;
		logic             ready;
		logic             pack_on;
		logic             array_on;
		logic             halted;
	} state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
	endfunction

	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    res_valid_q;
	state_t  st_q;
	state_t  st_n;
	logic    trip;
	logic    advance;
	logic    fire;

	logic        [15:0] vmin;
	logic        [15:0] vmax;
	logic signed [15:0] cur;
	logic signed [11:0] temp;
	logic signed [15:0] chg;
	logic signed [15:0] dis;
	logic signed [11:0] tlim;
	logic               vbad;
	logic               ibad;
	logic               tbad;
	logic               in_limits;
	logic               skip;

	assign advance    = !res_valid_q || result.ready;
	assign fire       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	assign vmin = item_s1.min_cell_mv;
	assign vmax = item_s1.max_cell_mv;
	assign cur  = item_s1.pack_current;
	assign temp = item_s1.hottest_temp;
	assign chg  = cfg.charge_limit;
	assign dis  = cfg.discharge_limit;
	assign tlim = cfg.temp_limit;

	assign vbad = (vmin < cfg.crit_min_mv) || (vmax > cfg.crit_max_mv);
	assign ibad = (cur < chg) || (cur > dis);
	assign tbad = (temp > tlim);
	assign in_limits = (vmin > cfg.crit_min_mv) && (vmax < cfg.crit_max_mv) &&
		(cur > chg) && (cur < dis) && (temp < tlim);

	always_comb begin
		st_n = st_q;
		trip = 1'b0;
		skip = 1'b0;
		if (!st_q.halted) begin
			st_n.volt_cnt = vbad ? sat_inc(st_q.volt_cnt) : '0;
			st_n.cur_cnt  = ibad ? sat_inc(st_q.cur_cnt)  : '0;
			st_n.temp_cnt = tbad ? sat_inc(st_q.temp_cnt) : '0;

			if ((st_n.volt_cnt > VOLT_TRIP_COUNT) || (st_n.cur_cnt > CURRENT_TRIP_COUNT) ||
				(st_n.temp_cnt > TEMP_TRIP_COUNT)) begin
				trip           = 1'b1;
				st_n.pack_on   = 1'b0;
				st_n.array_on  = 1'b0;
				if (st_q.ready) begin
					st_n.halted = 1'b1;
					skip        = 1'b1;
				end
			end

			if (!skip && in_limits) begin
				st_n.ready = 1'b1;
				if ((vmin >= cfg.rec_min_mv) && (vmax <= cfg.rec_max_mv) &&
					!st_q.uv_latch && !st_q.ov_latch) begin
					st_n.pack_on  = 1'b1;
					st_n.array_on = 1'b1;
				end else if ((vmin < cfg.rec_min_mv) && !st_q.uv_latch) begin
					st_n.uv_cnt = sat_inc(st_q.uv_cnt);
					if (st_n.uv_cnt > BAND_DEBOUNCE_COUNT) begin
						st_n.pack_on  = 1'b0;
						st_n.array_on = 1'b1;
						st_n.uv_latch = 1'b1;
						st_n.uv_cnt   = '0;
					end
				end else if ((vmax > cfg.rec_max_mv) && !st_q.ov_latch) begin
					st_n.ov_cnt = sat_inc(st_q.ov_cnt);
					if (st_n.ov_cnt > BAND_DEBOUNCE_COUNT) begin
						st_n.pack_on  = 1'b1;
						st_n.array_on = 1'b0;
						st_n.ov_latch = 1'b1;
						st_n.ov_cnt   = '0;
					end
				end else if ((vmax < cfg.caution_max_mv) && st_q.ov_latch) begin
					st_n.ov_clr_cnt = sat_inc(st_q.ov_clr_cnt);
					if (st_n.ov_clr_cnt > BAND_DEBOUNCE_COUNT) begin
						st_n.pack_on    = 1'b1;
						st_n.array_on   = 1'b1;
						st_n.ov_latch   = 1'b0;
						st_n.ov_clr_cnt = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				st_q <= st_n;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.pack_enable       <= st_n.pack_on;
			res_q.array_enable      <= st_n.array_on;
			res_q.undervolt_latched <= st_n.uv_latch;
			res_q.overvolt_latched  <= st_n.ov_latch;
			res_q.system_ready      <= st_n.ready;
			res_q.fault_trip        <= trip;
			res_q.shutdown_halted   <= st_n.halted;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

// File: rtl/core/battery_protection_supervisor.sv
// ---------------------------------------------------------------------------
// battery_protection_supervisor
// Critical-limit fault counting, band debounce and contactor control.
//
// Each measurement word enters on the item channel (valid/ready)
// and yields exactly one result word on the result channel: contactor
// drives, latch states, ready, trip and shutdown flags.
// An accepted word passes through the input register, then the result
// register. Throughput: one word per cycle while the receiver does not
// stall; the input register feeds the state update and result register
// directly, so a new word enters every cycle while results drain.
// When the receiver stalls, the result word holds and the input register
// keeps one more word; item.ready drops once both are full.
// Limits sit in an APB-style register file, reset to their defaults. The user
// must write them only while the block is idle; the block does not enforce it.
// Reset opens both contactors, clears all counters and latches and leaves
// no result pending. Once permanent shutdown latches, every further word
// returns the frozen state with shutdown_halted set.
// ---------------------------------------------------------------------------
module battery_protection_supervisor
	import bps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	bps_item_if.sink              item,
	bps_result_if.source          result
);

	cfg_t cfg;

	bps_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.result (result)
	);

endmodule

// File: rtl/core/bps_checker.sv
// ---------------------------------------------------------------------------
// bps_checker
// Port-level checks on result words, bound to the top level.
// ---------------------------------------------------------------------------
`include "battery_protection_supervisor_assert.svh"

module bps_checker
	import bps_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    res_valid,
	input logic    res_ready,
	input result_t res_data
);

	logic res_stall;
	logic res_trip;
	logic res_trip_rdy;
	logic res_halt;
	logic res_open;

	assign res_stall    = res_valid && !res_ready;
	assign res_trip     = res_valid && res_data.fault_trip;
	assign res_trip_rdy = res_trip && res_data.system_ready;
	assign res_halt     = res_valid && res_data.shutdown_halted;
	assign res_open     = !res_data.pack_enable && !res_data.array_enable;

	`BPS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_stall, res_valid && $stable(res_data))
	`BPS_ASSERT_IMPL(a_trip_opens, clk, arst_n, res_trip, res_open)
	`BPS_ASSERT_IMPL(a_trip_ready_halts, clk, arst_n, res_trip_rdy, res_data.shutdown_halted)
	`BPS_ASSERT_IMPL(a_halt_open, clk, arst_n, res_halt, res_open)

endmodule

bind battery_protection_supervisor bps_checker u_bps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);
